// ===== design/rit_pkg.sv =====
`default_nettype none

package rit_pkg;

   // Word widths
   localparam int VALUE_BITS = 32;
   localparam int RADIX_W    = 6;
   localparam int DIG_W      = RADIX_W;
   localparam int CHAR_W     = 7;

   // Divider: quotient bits retired per cycle and division steps per digit
   localparam int STEP_BITS  = 8;
   localparam int STEPS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_W      = STEPS * STEP_BITS;
   localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   // Digit stack sizing
   localparam int STACK_AW   = $clog2(VALUE_BITS);
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);

   // Base handling
   localparam logic [RADIX_W-1:0] BASE_MIN     = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] BASE_MAX     = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] BASE_DEFAULT = RADIX_W'(10);
   localparam logic [DIG_W-1:0]   DIGIT_TEN    = DIG_W'(10);

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic push;
      logic emit_sign;
      logic pop;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic quot_zero;
      logic negative;
      logic last_digit;
      logic out_free;
   } status_type;

   // Digit value to ASCII glyph
   function automatic logic [CHAR_W-1:0] glyph(input logic [DIG_W-1:0] d, input logic upper);
      logic [CHAR_W-1:0] letter_base;
      letter_base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (d < DIGIT_TEN) begin
         glyph = CHAR_ZERO + CHAR_W'(d);
      end else begin
         glyph = letter_base + CHAR_W'(d - DIGIT_TEN);
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/rit_ctrl.sv =====
`default_nettype none

module rit_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire rit_pkg::status_type status,
   output rit_pkg::cmd_type        cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam logic [rit_pkg::STEP_CNT_W-1:0] STEP_LAST =
      rit_pkg::STEP_CNT_W'(rit_pkg::STEPS - 1);

   logic [1:0]                       state_ff, state_in;
   logic [rit_pkg::STEP_CNT_W-1:0]   step_ff, step_in;

   // No word is taken while in reset or busy
   assign req_stall = reset || (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_LAST) begin
               // digit done: push remainder, stop once quotient is zero
               cmd.push = 1'b1;
               step_in  = '0;
               if (status.quot_zero) begin
                  state_in = status.negative ? ST_SIGN : ST_EMIT;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.pop = 1'b1;
               if (status.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/rit_datapath.sv =====
`default_nettype none

module rit_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rit_pkg::cmd_type                    cmd,
   output rit_pkg::status_type                      status,
   input  wire logic signed [rit_pkg::VALUE_BITS-1:0] req_value,
   input  wire logic [rit_pkg::RADIX_W-1:0]         req_radix,
   input  wire logic                                req_upper_case,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [rit_pkg::CHAR_W-1:0]               rsp_character,
   output logic                                     rsp_last
);

   logic [rit_pkg::PAD_W-1:0]      div_ff, div_in;
   logic [rit_pkg::DIG_W-1:0]      rem_ff, rem_in;
   logic [rit_pkg::RADIX_W-1:0]    base_ff;
   logic                           upper_ff;
   logic                           neg_ff;
   logic [rit_pkg::CNT_W-1:0]      count_ff;
   logic [rit_pkg::DIG_W-1:0]      stack_ff [rit_pkg::VALUE_BITS];
   logic                           valid_ff;
   logic [rit_pkg::CHAR_W-1:0]     char_ff;
   logic                           last_ff;

   logic                           value_neg;
   logic [rit_pkg::VALUE_BITS-1:0] value_mag;
   logic [rit_pkg::RADIX_W-1:0]    base_norm;
   logic [rit_pkg::CNT_W-1:0]      count_dec;
   logic [rit_pkg::DIG_W:0]        trial;
   logic                           out_free;

   // Magnitude and base normalization at load
   assign value_neg = req_value[rit_pkg::VALUE_BITS-1];
   assign value_mag = value_neg ? (~req_value + 1'b1) : req_value;
   assign base_norm = ((req_radix < rit_pkg::BASE_MIN) || (req_radix > rit_pkg::BASE_MAX))
                      ? rit_pkg::BASE_DEFAULT : req_radix;

   // Restoring division, STEP_BITS quotient bits per cycle, quotient shifts in
   always_comb begin
      rem_in = rem_ff;
      div_in = div_ff;
      trial  = '0;
      for (int i = 0; i < rit_pkg::STEP_BITS; i++) begin
         trial  = {rem_in, div_in[rit_pkg::PAD_W-1]};
         div_in = {div_in[rit_pkg::PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, base_ff}) begin
            rem_in    = rit_pkg::DIG_W'(trial - {1'b0, base_ff});
            div_in[0] = 1'b1;
         end else begin
            rem_in = trial[rit_pkg::DIG_W-1:0];
         end
      end
   end

   assign count_dec = count_ff - 1'b1;
   assign out_free  = !valid_ff || !rsp_stall;

   assign status.quot_zero  = (div_in == '0);
   assign status.negative   = neg_ff;
   assign status.last_digit = (count_ff == rit_pkg::CNT_W'(1));
   assign status.out_free   = out_free;

   // Operand registers and divider state
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         div_ff   <= rit_pkg::PAD_W'(value_mag);
         rem_ff   <= '0;
         base_ff  <= base_norm;
         upper_ff <= req_upper_case;
         neg_ff   <= value_neg;
      end else if (cmd.div_step) begin
         div_ff <= div_in;
         rem_ff <= cmd.push ? '0 : rem_in;
      end
   end

   // Digit stack
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_ff[count_ff[rit_pkg::STACK_AW-1:0]] <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.push) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_ff <= count_dec;
      end
   end

   // Output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         char_ff <= rit_pkg::CHAR_MINUS;
         last_ff <= 1'b0;
      end else if (cmd.pop) begin
         char_ff <= rit_pkg::glyph(stack_ff[count_dec[rit_pkg::STACK_AW-1:0]], upper_ff);
         last_ff <= status.last_digit;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// ===== design/radix_integer_to_text_unit.sv =====
`default_nettype none
// Order: a number is divided one digit at a time, eight quotient bits per cycle, and all its digits
//   are on the digit stack before its first character leaves the output register.
// Throughput: one character per cycle while emitting and rsp_stall is low; a new word is taken
//   only once the controller is idle again, after the last digit of the previous word is popped.
// Reset: synchronous, active high; clears the controller, digit count and output valid.
//   The digit stack is not cleared.

module radix_integer_to_text_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [rit_pkg::VALUE_BITS-1:0] req_value,
   input  wire logic [rit_pkg::RADIX_W-1:0]         req_radix,
   input  wire logic                                req_upper_case,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [rit_pkg::CHAR_W-1:0]               rsp_character,
   output logic                                     rsp_last
);

   rit_pkg::cmd_type    cmd;
   rit_pkg::status_type status;

   // Sequencer
   rit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Divider, digit stack and output register
   rit_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .req_upper_case (req_upper_case),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/tb_radix_integer_to_text_unit.sv =====
`timescale 1ns / 100ps

module tb_radix_integer_to_text_unit;
   import rit_pkg::*;

   localparam int IDLE_LIMIT     = 4000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int RANDOM_NUMBERS = 160;

   typedef struct {
      logic signed [VALUE_BITS-1:0] value;
      logic [RADIX_W-1:0]           radix;
      logic                         upper_case;
   } number_word_type;

   typedef struct {
      logic [CHAR_W-1:0] character;
      logic              last;
   } char_word_type;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic                         req_stall;
   logic signed [VALUE_BITS-1:0] req_value      = '0;
   logic [RADIX_W-1:0]           req_radix      = '0;
   logic                         req_upper_case = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall      = 1'b0;
   logic [CHAR_W-1:0]            rsp_character;
   logic                         rsp_last;

   number_word_type pending_numbers[$];
   char_word_type   expected_chars[$];
   number_word_type shown_number;
   int accepted_numbers = 0;
   int queued_numbers   = 0;
   int error_count      = 0;
   int idle_cycles      = 0;
   int burst_left       = 0;
   int gap_left         = 0;
   int stall_mode       = 0;
   int stall_mode_left  = 0;
   int stall_phase      = 0;

   radix_integer_to_text_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .req_radix      (req_radix),
      .req_upper_case (req_upper_case),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch @%0t: %s", $time, what);
      error_count++;
   endtask

   // Expected text of one number: optional sign, then digits MSB first
   function automatic void predict_text(input number_word_type num);
      logic [VALUE_BITS-1:0] magnitude;
      int unsigned           base;
      int unsigned           digits[$];
      int unsigned           d;
      char_word_type         c;
      base = 32'(num.radix);
      if (base < 32'(BASE_MIN) || base > 32'(BASE_MAX)) base = 32'(BASE_DEFAULT);
      if (num.value == 0) begin
         c.character = CHAR_ZERO;
         c.last      = 1'b1;
         expected_chars.push_back(c);
         return;
      end
      // most negative value wraps to 2^(N-1) read as unsigned
      magnitude = num.value[VALUE_BITS-1] ? -num.value : num.value;
      if (num.value[VALUE_BITS-1]) begin
         c.character = CHAR_MINUS;
         c.last      = 1'b0;
         expected_chars.push_back(c);
      end
      while (magnitude != 0) begin
         digits.push_front(magnitude % base);
         magnitude = magnitude / base;
      end
      foreach (digits[i]) begin
         d = digits[i];
         if (d < 10) c.character = CHAR_ZERO + CHAR_W'(d);
         else c.character = (num.upper_case ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(d - 10);
         c.last = (i == digits.size() - 1);
         expected_chars.push_back(c);
      end
   endfunction

   function automatic void add_number(input logic signed [VALUE_BITS-1:0] value,
                                      input int radix, input bit upper_case);
      number_word_type num;
      num.value      = value;
      num.radix      = RADIX_W'(radix);
      num.upper_case = upper_case;
      pending_numbers.push_back(num);
      queued_numbers++;
   endfunction

   // Mix of full-range, small, extreme and shifted values
   function automatic void add_random_number();
      logic signed [VALUE_BITS-1:0] value;
      int                           radix;
      int                           pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: value = $urandom;
         3, 4:    value = $urandom_range(0, 1000);
         5: begin
            case ($urandom_range(0, 4))
               0:       value = 0;
               1:       value = -1;
               2:       value = 1;
               3:       value = 32'sh7FFF_FFFF;
               default: value = 32'sh8000_0000;
            endcase
         end
         6, 7:    value = $urandom >> $urandom_range(0, 31);
         default: value = -$signed(32'($urandom_range(1, 5000)));
      endcase
      if (pick >= 3 && pick <= 7 && $urandom_range(0, 1) == 1) value = -value;
      if ($urandom_range(0, 9) == 0) radix = $urandom_range(0, 63);
      else radix = $urandom_range(2, 36);
      add_number(value, radix, 1'($urandom_range(0, 1)));
   endfunction

   // Driver: bursts of words with random gaps, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_text(shown_number);
            accepted_numbers++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_numbers.size() != 0) begin
               shown_number = pending_numbers.pop_front();
               req_value      <= shown_number.value;
               req_radix      <= shown_number.radix;
               req_upper_case <= shown_number.upper_case;
               req_valid      <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 11);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall pattern: free, light, heavy or periodic phases
   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      = $urandom_range(0, 3);
         stall_mode_left = $urandom_range(50, 300);
      end else begin
         stall_mode_left--;
      end
      stall_phase++;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_phase % 3) == 0);
      endcase
   end

   // Monitor: each accepted character against the oldest expectation
   always @(posedge clock) begin : char_check
      char_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character %h last %b",
                                      rsp_character, rsp_last));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_character !== want.character)
               report_mismatch($sformatf("character %h, expected %h",
                                         rsp_character, want.character));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, expected %b on character %h",
                                         rsp_last, want.last, want.character));
         end
      end
   end

   // Watchdog: too long without any handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("[radix_integer_to_text_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // directed: zero, extremes, sign, both letter cases, bases out of range
      add_number(0, 10, 1'b0);
      add_number(0, 2, 1'b1);
      add_number(1, 2, 1'b0);
      add_number(-1, 10, 1'b0);
      add_number(-1, 2, 1'b1);
      add_number(32'sh7FFF_FFFF, 2, 1'b0);
      add_number(32'sh7FFF_FFFF, 36, 1'b1);
      add_number(32'sh8000_0000, 2, 1'b0);
      add_number(32'sh8000_0000, 16, 1'b1);
      add_number(32'sh8000_0000, 36, 1'b0);
      add_number(35, 36, 1'b0);
      add_number(35, 36, 1'b1);
      add_number(36, 36, 1'b0);
      add_number(1295, 36, 1'b1);
      add_number(255, 16, 1'b0);
      add_number(255, 16, 1'b1);
      add_number(-255, 16, 1'b1);
      add_number(7, 3, 1'b0);
      add_number(100, 10, 1'b0);
      add_number(12345, 0, 1'b0);
      add_number(12345, 1, 1'b0);
      add_number(12345, 37, 1'b0);
      add_number(-12345, 63, 1'b1);
      repeat (RANDOM_NUMBERS) add_random_number();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (accepted_numbers != queued_numbers || expected_chars.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("[radix_integer_to_text_unit] OK");
      end else begin
         $display("[radix_integer_to_text_unit] ERROR");
      end
      $finish;
   end

endmodule
